>>> src/ledanim_pkg.sv
// ----------------------------------------------------------------------------
// ledanim_pkg: shared types and constants for the LED animation core
// Pixel counts, mode and register codes, command/status structs, hue wheel.
// ----------------------------------------------------------------------------
package ledanim_pkg;

   localparam int MAX_PIXELS = 32;
   localparam int IDX_W      = $clog2(MAX_PIXELS);
   localparam int LEN_W      = 6;
   localparam int STEP_W     = 9;
   localparam int COLOR_W    = 24;
   localparam int LEVEL_W    = 8;

   // register indexes
   localparam logic [1:0] REG_POWER  = 2'd0;
   localparam logic [1:0] REG_MODE   = 2'd1;
   localparam logic [1:0] REG_COLOR  = 2'd2;
   localparam logic [1:0] REG_LENGTH = 2'd3;

   // animation modes
   localparam logic [2:0] MODE_SOLID   = 3'd0;
   localparam logic [2:0] MODE_BREATHE = 3'd1;
   localparam logic [2:0] MODE_WIPE    = 3'd2;
   localparam logic [2:0] MODE_CHASE   = 3'd3;
   localparam logic [2:0] MODE_RAINBOW = 3'd4;
   localparam logic [2:0] MODE_RCHASE  = 3'd5;
   localparam logic [2:0] MODE_NONE    = 3'd7;

   localparam logic [STEP_W-1:0] STEP_WRAP = STEP_W'(256);

   typedef enum logic [2:0] {
      PASS_CLEAR,
      PASS_FILL,
      PASS_WIPE,
      PASS_CHASE,
      PASS_RAINBOW,
      PASS_RCHASE
   } pass_kind_type;

   typedef struct packed {
      logic                start;
      pass_kind_type       kind;
      logic                emit;
      logic                last;
      logic [STEP_W-1:0]   step;
      logic [1:0]          offset;
      logic                lit;
      logic                black;
      logic [LEVEL_W-1:0]  bright;
   } pass_cmd_type;

   typedef struct packed {
      logic done;
   } pass_status_type;

   // color wheel: green->red->blue thirds
   function automatic logic [COLOR_W-1:0] hue_to_rgb(input logic [7:0] pos);
      logic [7:0] rel;
      logic [7:0] up;
      logic [7:0] down;
      logic [9:0] tri_val;
      if (pos < 8'd85) begin
         rel = pos;
      end else if (pos < 8'd170) begin
         rel = pos - 8'd85;
      end else begin
         rel = pos - 8'd170;
      end
      tri_val = {2'b00, rel} + {1'b0, rel, 1'b0};
      up      = tri_val[7:0];
      down    = 8'd255 - up;
      if (pos < 8'd85) begin
         hue_to_rgb = {up, down, 8'd0};
      end else if (pos < 8'd170) begin
         hue_to_rgb = {down, 8'd0, up};
      end else begin
         hue_to_rgb = {8'd0, up, down};
      end
   endfunction

endpackage

>>> src/ledanim_dpath.sv
// ----------------------------------------------------------------------------
// ledanim_dpath: strip image, pixel sweep and output word register
// Runs one strip pass per command, one pixel a cycle unless rsp stalls.
// ----------------------------------------------------------------------------
module ledanim_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ledanim_pkg::pass_cmd_type             cmd,
   output ledanim_pkg::pass_status_type          status,
   input  logic [ledanim_pkg::COLOR_W-1:0]       base_color,
   input  logic [ledanim_pkg::LEN_W-1:0]         len_m1,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [4:0]                            rsp_pixel_index,
   output logic [ledanim_pkg::COLOR_W-1:0]       rsp_pixel_color,
   output logic [ledanim_pkg::LEVEL_W-1:0]       rsp_brightness,
   output logic                                  rsp_frame_end,
   output logic                                  rsp_last
);

   logic [ledanim_pkg::COLOR_W-1:0] strip_ff [ledanim_pkg::MAX_PIXELS];
   logic [ledanim_pkg::COLOR_W-1:0] strip_in [ledanim_pkg::MAX_PIXELS];
   logic                             busy_ff,  busy_in;
   logic [ledanim_pkg::IDX_W-1:0]    pix_ff,   pix_in;
   logic [1:0]                       cnt3_ff,  cnt3_in;
   logic                             valid_ff, valid_in;
   logic [4:0]                       idx_ff,   idx_in;
   logic [ledanim_pkg::COLOR_W-1:0]  color_ff, color_in;
   logic [ledanim_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic                             fend_ff,  fend_in;
   logic                             last_ff,  last_in;

   logic                             advance;
   logic                             end_pix;
   logic                             hit;
   logic [ledanim_pkg::IDX_W-1:0]    k_rel;
   logic [9:0]                       hsum;
   logic [9:0]                       hmod;
   logic [7:0]                       rb_pos;
   logic [ledanim_pkg::COLOR_W-1:0]  old_color;
   logic [ledanim_pkg::COLOR_W-1:0]  new_color;
   logic [ledanim_pkg::COLOR_W-1:0]  lit_color;

   assign old_color = strip_ff[pix_ff];
   assign end_pix   = ({1'b0, pix_ff} == len_m1[ledanim_pkg::IDX_W:0]);
   assign advance   = busy_ff && (!cmd.emit || !valid_ff || !rsp_stall);
   assign hit       = (pix_ff >= ledanim_pkg::IDX_W'(cmd.offset)) && (cnt3_ff == 2'd0);
   assign k_rel     = pix_ff - ledanim_pkg::IDX_W'(cmd.offset);

   // rainbow chase hue: (step + k) mod 255
   assign hsum   = {1'b0, cmd.step} + 10'(k_rel);
   assign hmod   = (hsum >= 10'd255) ? hsum - 10'd255 : hsum;
   assign rb_pos = cmd.step[7:0] + 8'(pix_ff);

   always_comb begin
      lit_color = (cmd.kind == ledanim_pkg::PASS_RCHASE) ?
                  ledanim_pkg::hue_to_rgb(hmod[7:0]) : base_color;
      case (cmd.kind)
         ledanim_pkg::PASS_CLEAR:   new_color = '0;
         ledanim_pkg::PASS_FILL:    new_color = base_color;
         ledanim_pkg::PASS_WIPE: begin
            if (ledanim_pkg::STEP_W'(pix_ff) < cmd.step) begin
               new_color = cmd.black ? '0 : base_color;
            end else begin
               new_color = old_color;
            end
         end
         ledanim_pkg::PASS_CHASE, ledanim_pkg::PASS_RCHASE: begin
            if (hit) begin
               new_color = cmd.lit ? lit_color : '0;
            end else begin
               new_color = old_color;
            end
         end
         ledanim_pkg::PASS_RAINBOW: new_color = ledanim_pkg::hue_to_rgb(rb_pos);
         default:                   new_color = old_color;
      endcase
   end

   always_comb begin
      strip_in = strip_ff;
      busy_in  = busy_ff;
      pix_in   = pix_ff;
      cnt3_in  = cnt3_ff;
      valid_in = valid_ff && rsp_stall;
      idx_in   = idx_ff;
      color_in = color_ff;
      level_in = level_ff;
      fend_in  = fend_ff;
      last_in  = last_ff;
      status.done = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         pix_in  = '0;
         // phase of (pixel - offset) mod 3 at pixel 0
         case (cmd.offset)
            2'd1:    cnt3_in = 2'd2;
            2'd2:    cnt3_in = 2'd1;
            default: cnt3_in = 2'd0;
         endcase
      end else if (advance) begin
         strip_in[pix_ff] = new_color;
         pix_in  = pix_ff + 1'b1;
         cnt3_in = (cnt3_ff == 2'd2) ? 2'd0 : cnt3_ff + 2'd1;
         if (cmd.emit) begin
            valid_in = 1'b1;
            idx_in   = 5'(pix_ff);
            color_in = new_color;
            level_in = cmd.bright;
            fend_in  = end_pix;
            last_in  = end_pix && cmd.last;
         end
         if (end_pix) begin
            busy_in     = 1'b0;
            status.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ledanim_pkg::MAX_PIXELS; i++) begin
            strip_ff[i] <= '0;
         end
         busy_ff  <= 1'b0;
         pix_ff   <= '0;
         cnt3_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         strip_ff <= strip_in;
         busy_ff  <= busy_in;
         pix_ff   <= pix_in;
         cnt3_ff  <= cnt3_in;
         valid_ff <= valid_in;
      end
      idx_ff   <= idx_in;
      color_ff <= color_in;
      level_ff <= level_in;
      fend_ff  <= fend_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_pixel_index = idx_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_brightness  = level_ff;
   assign rsp_frame_end   = fend_ff;
   assign rsp_last        = last_ff;

endmodule

>>> src/ledanim_ctrl.sv
// ----------------------------------------------------------------------------
// ledanim_ctrl: per-tick sequencer and animation counters
// Plans the clear and mode passes of a tick and steps the animation state.
// ----------------------------------------------------------------------------
module ledanim_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_frame_tick,
   input  logic                                power_on,
   input  logic [2:0]                          animation_mode,
   input  logic [ledanim_pkg::LEN_W-1:0]       len,
   output ledanim_pkg::pass_cmd_type           cmd,
   input  ledanim_pkg::pass_status_type        status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ACT
   } state_type;

   state_type                          state_ff,  state_in;
   ledanim_pkg::pass_cmd_type          cmd_ff,    cmd_in;
   ledanim_pkg::pass_cmd_type          act_ff,    act_in;
   logic                               pend_ff,   pend_in;
   logic [ledanim_pkg::STEP_W-1:0]     step_ff,   step_in;
   logic [1:0]                         off_ff,    off_in;
   logic                               fall_ff,   fall_in;
   logic                               wclr_ff,   wclr_in;
   logic                               lit_ff,    lit_in;
   logic [2:0]                         prev_ff,   prev_in;
   logic [ledanim_pkg::LEVEL_W-1:0]    level_ff,  level_in;

   always_comb begin
      logic                            accept;
      logic                            changed;
      logic [ledanim_pkg::STEP_W-1:0]  e_step, n_step;
      logic [1:0]                      e_off,  n_off;
      logic                            e_fall, n_fall;
      logic                            e_wclr, n_wclr;
      logic                            e_lit,  n_lit;
      logic [ledanim_pkg::LEVEL_W-1:0] n_level;
      logic                            act_go;
      ledanim_pkg::pass_cmd_type       act_cmd;
      ledanim_pkg::pass_cmd_type       clr_cmd;

      accept  = req_valid && (state_ff == ST_IDLE);
      changed = (prev_ff != animation_mode);
      e_step  = changed ? '0 : step_ff;
      e_off   = changed ? 2'd0 : off_ff;
      e_fall  = changed ? 1'b0 : fall_ff;
      e_wclr  = changed ? 1'b0 : wclr_ff;
      e_lit   = changed ? 1'b0 : lit_ff;
      n_step  = e_step;
      n_off   = e_off;
      n_fall  = e_fall;
      n_wclr  = e_wclr;
      n_lit   = e_lit;
      n_level = level_ff;
      act_go  = 1'b0;

      act_cmd.start  = 1'b1;
      act_cmd.kind   = ledanim_pkg::PASS_FILL;
      act_cmd.emit   = 1'b1;
      act_cmd.last   = 1'b1;
      act_cmd.step   = e_step;
      act_cmd.offset = e_off;
      act_cmd.lit    = 1'b0;
      act_cmd.black  = e_wclr;
      act_cmd.bright = level_ff;

      clr_cmd        = act_cmd;
      clr_cmd.kind   = ledanim_pkg::PASS_CLEAR;

      unique case (animation_mode)
         ledanim_pkg::MODE_SOLID: begin
            act_go = 1'b1;
         end
         ledanim_pkg::MODE_BREATHE: begin
            if (!e_fall) begin
               if (e_step < ledanim_pkg::STEP_WRAP) begin
                  act_go  = 1'b1;
                  n_level = e_step[7:0];
                  n_step  = e_step + 1'b1;
               end else begin
                  n_fall = 1'b1;
                  n_step = e_step - 1'b1;
               end
            end else begin
               act_go  = 1'b1;
               n_level = e_step[7:0];
               if (e_step == '0) begin
                  n_fall = 1'b0;
               end else begin
                  n_step = e_step - 1'b1;
               end
            end
         end
         ledanim_pkg::MODE_WIPE: begin
            act_go       = 1'b1;
            act_cmd.kind = ledanim_pkg::PASS_WIPE;
            n_step       = e_step + 1'b1;
            if (e_step >= ledanim_pkg::STEP_W'(len)) begin
               n_wclr = !e_wclr;
               n_step = '0;
            end
         end
         ledanim_pkg::MODE_CHASE: begin
            if (e_step < ledanim_pkg::STEP_W'(3)) begin
               act_go         = 1'b1;
               act_cmd.kind   = ledanim_pkg::PASS_CHASE;
               act_cmd.offset = e_step[1:0];
               act_cmd.lit    = !e_lit;
               act_cmd.emit   = !e_lit;
               n_lit          = !e_lit;
               if (e_lit) begin
                  n_step = e_step + 1'b1;
               end
            end else begin
               n_step = '0;
            end
         end
         ledanim_pkg::MODE_RAINBOW: begin
            if (e_step < ledanim_pkg::STEP_WRAP) begin
               act_go       = 1'b1;
               act_cmd.kind = ledanim_pkg::PASS_RAINBOW;
               n_step       = e_step + 1'b1;
            end else begin
               n_step = '0;
            end
         end
         ledanim_pkg::MODE_RCHASE: begin
            if (e_step < ledanim_pkg::STEP_WRAP) begin
               if (e_off < 2'd3) begin
                  act_go       = 1'b1;
                  act_cmd.kind = ledanim_pkg::PASS_RCHASE;
                  act_cmd.lit  = !e_lit;
                  act_cmd.emit = !e_lit;
                  n_lit        = !e_lit;
                  if (e_lit) begin
                     n_off = e_off + 2'd1;
                  end
               end else begin
                  n_step = e_step + 1'b1;
                  n_off  = 2'd0;
               end
            end else begin
               n_step = '0;
               n_off  = 2'd0;
            end
         end
         default: begin
            act_go = 1'b0;
         end
      endcase

      state_in  = state_ff;
      cmd_in    = cmd_ff;
      cmd_in.start = 1'b0;
      act_in    = act_ff;
      pend_in   = pend_ff;
      step_in   = step_ff;
      off_in    = off_ff;
      fall_in   = fall_ff;
      wclr_in   = wclr_ff;
      lit_in    = lit_ff;
      prev_in   = prev_ff;
      level_in  = level_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_frame_tick) begin
               if (!power_on) begin
                  cmd_in   = clr_cmd;
                  pend_in  = 1'b0;
                  state_in = ST_CLEAR;
               end else begin
                  step_in  = n_step;
                  off_in   = n_off;
                  fall_in  = n_fall;
                  wclr_in  = n_wclr;
                  lit_in   = n_lit;
                  level_in = n_level;
                  prev_in  = animation_mode;
                  if (changed) begin
                     cmd_in      = clr_cmd;
                     cmd_in.last = !(act_go && act_cmd.emit);
                     pend_in     = act_go;
                     act_in      = act_cmd;
                     state_in    = ST_CLEAR;
                  end else if (act_go) begin
                     cmd_in   = act_cmd;
                     state_in = ST_ACT;
                  end
               end
            end
         end
         ST_CLEAR: begin
            if (status.done) begin
               if (pend_ff) begin
                  cmd_in   = act_ff;
                  state_in = ST_ACT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ACT: begin
            if (status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cmd_ff    <= '0;
         act_ff    <= '0;
         pend_ff   <= 1'b0;
         step_ff   <= '0;
         off_ff    <= 2'd0;
         fall_ff   <= 1'b0;
         wclr_ff   <= 1'b0;
         lit_ff    <= 1'b0;
         prev_ff   <= ledanim_pkg::MODE_NONE;
         level_ff  <= '1;
      end else begin
         state_ff  <= state_in;
         cmd_ff    <= cmd_in;
         act_ff    <= act_in;
         pend_ff   <= pend_in;
         step_ff   <= step_in;
         off_ff    <= off_in;
         fall_ff   <= fall_in;
         wclr_ff   <= wclr_in;
         lit_ff    <= lit_in;
         prev_ff   <= prev_in;
         level_ff  <= level_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign cmd       = cmd_ff;

endmodule

>>> src/led_strip_animation_frame_generator_core.sv
// ----------------------------------------------------------------------------
// led_strip_animation_frame_generator_core: addressable-LED animation engine
// Steps one animation frame per tick word and streams shown frames as pixels.
// ----------------------------------------------------------------------------
// Each accepted req word with frame_tick set advances the selected animation
// by one step while power is on (power off shows a black frame). Whenever a
// frame is shown, the stored strip image streams out on rsp as one word per
// pixel (index, 24-bit color, brightness), frame_end on the last pixel of
// the frame and last on the final word of the tick. Work is done in passes
// over the strip, one pixel per cycle unless rsp stall holds the sweep: a
// tick runs one pass (a chase blanking step runs such a pass too, though it
// shows nothing), a clearing pass and then the mode's own pass when the
// mode changes, and no pass when the step only moves counters. A new tick
// is taken only after the previous tick's passes finish, while its final
// pixel word may still wait in the output register.
// Configuration (csr_index 0 power, 1 mode, 2 color, 3 length) may be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module led_strip_animation_frame_generator_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_frame_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [4:0]                          rsp_pixel_index,
   output logic [ledanim_pkg::COLOR_W-1:0]     rsp_pixel_color,
   output logic [ledanim_pkg::LEVEL_W-1:0]     rsp_brightness,
   output logic                                rsp_frame_end,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [1:0]                          csr_index,
   input  logic [ledanim_pkg::COLOR_W-1:0]     csr_data
);

   // configuration registers
   logic                             power_ff,  power_in;
   logic [2:0]                       mode_ff,   mode_in;
   logic [ledanim_pkg::COLOR_W-1:0]  color_ff,  color_in;
   logic [ledanim_pkg::LEN_W-1:0]    length_ff, length_in;

   logic [ledanim_pkg::LEN_W-1:0]    len;
   logic [ledanim_pkg::LEN_W-1:0]    len_m1;

   ledanim_pkg::pass_cmd_type        cmd;
   ledanim_pkg::pass_status_type     status;

   always_comb begin
      power_in  = power_ff;
      mode_in   = mode_ff;
      color_in  = color_ff;
      length_in = length_ff;
      if (csr_write) begin
         unique case (csr_index)
            ledanim_pkg::REG_POWER:  power_in  = csr_data[0];
            ledanim_pkg::REG_MODE:   mode_in   = csr_data[2:0];
            ledanim_pkg::REG_COLOR:  color_in  = csr_data;
            ledanim_pkg::REG_LENGTH: length_in = csr_data[ledanim_pkg::LEN_W-1:0];
            default:                 power_in  = power_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         power_ff  <= 1'b0;
         mode_ff   <= ledanim_pkg::MODE_SOLID;
         color_ff  <= '0;
         length_ff <= ledanim_pkg::LEN_W'(ledanim_pkg::MAX_PIXELS);
      end else begin
         power_ff  <= power_in;
         mode_ff   <= mode_in;
         color_ff  <= color_in;
         length_ff <= length_in;
      end
   end

   // pixels in use: zero acts as one, clipped at the strip size
   always_comb begin
      if (length_ff == '0) begin
         len = ledanim_pkg::LEN_W'(1);
      end else if (length_ff > ledanim_pkg::LEN_W'(ledanim_pkg::MAX_PIXELS)) begin
         len = ledanim_pkg::LEN_W'(ledanim_pkg::MAX_PIXELS);
      end else begin
         len = length_ff;
      end
      len_m1 = len - 1'b1;
   end

   ledanim_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_frame_tick (req_frame_tick),
      .power_on       (power_ff),
      .animation_mode (mode_ff),
      .len            (len),
      .cmd            (cmd),
      .status         (status)
   );

   ledanim_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .base_color      (color_ff),
      .len_m1          (len_m1),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_brightness  (rsp_brightness),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last        (rsp_last)
   );

endmodule

>>> bench/led_strip_animation_frame_generator_core_tb.sv
// ----------------------------------------------------------------------------
// led_strip_animation_frame_generator_core_tb: self-checking animation bench
// Drives frame tick words and register settings into the core. A cycle-free
// model of the animation state predicts every pixel word, and each word
// taken from rsp is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module led_strip_animation_frame_generator_core_tb;

   localparam int          HALF_PERIOD   = 6;
   localparam int          RESET_CYCLES  = 5;
   // worst tick is a clearing frame plus a mode frame
   localparam int          SETTLE_CYCLES = 2 * ledanim_pkg::MAX_PIXELS + 16;
   localparam int          CYCLE_LIMIT   = 1_000_000;
   localparam int          RANDOM_TICKS  = 55;
   // mode 6 has no name in the package; it behaves like an unknown mode
   localparam logic [2:0]  MODE_UNUSED   = 3'd6;

   typedef struct packed {
      logic [4:0]                       pix_index;
      logic [ledanim_pkg::COLOR_W-1:0]  pix_color;
      logic [ledanim_pkg::LEVEL_W-1:0]  pix_level;
      logic                             frame_end;
      logic                             last;
   } pixel_word_type;

   // DUT ports; everything driven is known from time zero
   logic                             clock          = 1'b0;
   logic                             reset          = 1'b1;
   logic                             req_valid      = 1'b0;
   logic                             req_stall;
   logic                             req_frame_tick = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall      = 1'b0;
   logic [4:0]                       rsp_pixel_index;
   logic [ledanim_pkg::COLOR_W-1:0]  rsp_pixel_color;
   logic [ledanim_pkg::LEVEL_W-1:0]  rsp_brightness;
   logic                             rsp_frame_end;
   logic                             rsp_last;
   logic                             csr_write      = 1'b0;
   logic [1:0]                       csr_index      = ledanim_pkg::REG_POWER;
   logic [ledanim_pkg::COLOR_W-1:0]  csr_data       = '0;

   // animation state as the block should hold it
   logic [ledanim_pkg::COLOR_W-1:0]  strip_img [ledanim_pkg::MAX_PIXELS];
   int unsigned                      step_cnt;
   int unsigned                      chase_ofs;
   bit                               breathe_down;
   bit                               wipe_black;
   bit                               chase_on;
   logic [2:0]                       shown_mode;
   logic [ledanim_pkg::LEVEL_W-1:0]  level;

   // register settings as last written
   bit                               cfg_power;
   logic [2:0]                       cfg_mode;
   logic [ledanim_pkg::COLOR_W-1:0]  cfg_color;
   logic [ledanim_pkg::LEN_W-1:0]    cfg_length;

   pixel_word_type       pending_pixels [$];   // predicted words not yet seen
   pixel_word_type       tick_words [$];       // words of the tick being predicted
   int unsigned          mismatch_count = 0;
   int unsigned          cycle_count    = 0;
   int unsigned          burst_left     = 0;
   bit                   gaps_on        = 1'b1;

   // receiver stall pattern
   int unsigned          stall_style    = 0;
   int unsigned          style_left     = 0;
   int unsigned          pattern_pos    = 0;
   logic [7:0]           stall_pattern  = '0;

   led_strip_animation_frame_generator_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_frame_tick  (req_frame_tick),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_brightness  (rsp_brightness),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last        (rsp_last),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // color wheel: red rises / green falls, then blue, then back to green
   function automatic logic [ledanim_pkg::COLOR_W-1:0] wheel_color(int unsigned pos);
      int unsigned p;
      p = pos % 256;
      if (p < 85) begin
         return {8'(p * 3), 8'(255 - p * 3), 8'd0};
      end
      if (p < 170) begin
         return {8'(255 - (p - 85) * 3), 8'd0, 8'((p - 85) * 3)};
      end
      return {8'd0, 8'((p - 170) * 3), 8'(255 - (p - 170) * 3)};
   endfunction

   function automatic void paint(int unsigned count,
                                 logic [ledanim_pkg::COLOR_W-1:0] color,
                                 int unsigned len);
      for (int unsigned p = 0; p < count && p < len; p++) begin
         strip_img[p] = color;
      end
   endfunction

   // one shown frame: every pixel in use, frame_end on the last one
   function automatic void show_strip(int unsigned len);
      pixel_word_type w;
      for (int unsigned p = 0; p < len; p++) begin
         w.pix_index = 5'(p);
         w.pix_color = strip_img[p];
         w.pix_level = level;
         w.frame_end = (p + 1 == len);
         w.last      = 1'b0;
         tick_words.push_back(w);
      end
   endfunction

   // every third pixel from offset; pixels past len stay as they were
   function automatic void place_chase(int unsigned offset, bit lit, bit rainbow,
                                       int unsigned len);
      logic [ledanim_pkg::COLOR_W-1:0] color;
      for (int unsigned k = 0; k < len; k += 3) begin
         color = '0;
         if (lit) begin
            color = rainbow ? wheel_color((step_cnt + k) % 255) : cfg_color;
         end
         if (offset + k < len) begin
            strip_img[offset + k] = color;
         end
      end
   endfunction

   // advances the animation by one accepted word and queues its pixel words
   function automatic void advance_frame(bit tick);
      int unsigned len;
      int unsigned idx;
      pixel_word_type w;
      // out-of-range lengths clamp to 1..MAX_PIXELS
      len = (cfg_length == 0) ? 1 :
            (cfg_length > ledanim_pkg::MAX_PIXELS) ? ledanim_pkg::MAX_PIXELS :
            int'(cfg_length);
      tick_words.delete();
      if (!tick) begin
         return;
      end
      if (!cfg_power) begin
         paint(len, '0, len);
         show_strip(len);
      end else begin
         // a new mode blanks the strip, shows it and restarts the counters
         if (shown_mode != cfg_mode) begin
            paint(len, '0, len);
            show_strip(len);
            step_cnt     = 0;
            chase_ofs    = 0;
            breathe_down = 1'b0;
            wipe_black   = 1'b0;
            chase_on     = 1'b0;
            shown_mode   = cfg_mode;
         end
         case (cfg_mode)
            ledanim_pkg::MODE_SOLID: begin
               paint(len, cfg_color, len);
               show_strip(len);
            end
            ledanim_pkg::MODE_BREATHE: begin
               // frame goes out with the old level, then level takes the step
               if (!breathe_down) begin
                  if (step_cnt < 256) begin
                     paint(len, cfg_color, len);
                     show_strip(len);
                     level    = 8'(step_cnt);
                     step_cnt = (step_cnt + 1) % 512;
                  end else begin
                     breathe_down = 1'b1;
                     step_cnt     = (step_cnt - 1) % 512;
                  end
               end else begin
                  paint(len, cfg_color, len);
                  show_strip(len);
                  level = 8'(step_cnt);
                  if (step_cnt == 0) begin
                     breathe_down = 1'b0;
                  end else begin
                     step_cnt = step_cnt - 1;
                  end
               end
            end
            ledanim_pkg::MODE_WIPE: begin
               idx      = step_cnt;
               step_cnt = (step_cnt + 1) % 512;
               paint(idx, wipe_black ? '0 : cfg_color, len);
               show_strip(len);
               // a shrunk length also ends the pass
               if (idx >= len) begin
                  wipe_black = !wipe_black;
                  step_cnt   = 0;
               end
            end
            ledanim_pkg::MODE_CHASE: begin
               if (step_cnt < 3) begin
                  if (!chase_on) begin
                     chase_on = 1'b1;
                     place_chase(step_cnt, 1'b1, 1'b0, len);
                     show_strip(len);
                  end else begin
                     // blanking step shows nothing
                     chase_on = 1'b0;
                     place_chase(step_cnt, 1'b0, 1'b0, len);
                     step_cnt++;
                  end
               end else begin
                  step_cnt = 0;
               end
            end
            ledanim_pkg::MODE_RAINBOW: begin
               if (step_cnt < 256) begin
                  for (int unsigned p = 0; p < len; p++) begin
                     strip_img[p] = wheel_color(step_cnt + p);
                  end
                  show_strip(len);
                  step_cnt++;
               end else begin
                  step_cnt = 0;
               end
            end
            ledanim_pkg::MODE_RCHASE: begin
               if (step_cnt < 256) begin
                  if (chase_ofs < 3) begin
                     if (!chase_on) begin
                        chase_on = 1'b1;
                        place_chase(chase_ofs, 1'b1, 1'b1, len);
                        show_strip(len);
                     end else begin
                        chase_on = 1'b0;
                        place_chase(chase_ofs, 1'b0, 1'b1, len);
                        chase_ofs = (chase_ofs + 1) % 4;
                     end
                  end else begin
                     step_cnt++;
                     chase_ofs = 0;
                  end
               end else begin
                  step_cnt  = 0;
                  chase_ofs = 0;
               end
            end
            default: begin
               // unknown modes only do the clear above
            end
         endcase
      end
      if (tick_words.size() > 0) begin
         w      = tick_words.pop_back();
         w.last = 1'b1;
         tick_words.push_back(w);
         foreach (tick_words[i]) begin
            pending_pixels.push_back(tick_words[i]);
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking: every word taken from rsp against the oldest prediction
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want,
                                       logic [31:0] got);
      if (want !== got) begin
         $error("pixel word %s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_pixels
      pixel_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected pixel word: index %0d color 0x%06h",
                   rsp_pixel_index, rsp_pixel_color);
            mismatch_count++;
         end else begin
            want = pending_pixels.pop_front();
            check_field("pixel_index", 32'(want.pix_index), 32'(rsp_pixel_index));
            check_field("pixel_color", 32'(want.pix_color), 32'(rsp_pixel_color));
            check_field("brightness",  32'(want.pix_level), 32'(rsp_brightness));
            check_field("frame_end",   32'(want.frame_end), 32'(rsp_frame_end));
            check_field("last",        32'(want.last),      32'(rsp_last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: switches at random between free-running, light, heavy and a
   // repeating random stall pattern
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style   = $urandom_range(0, 3);
            style_left    = $urandom_range(20, 300);
            stall_pattern = 8'($urandom) & 8'hFE;
         end
         style_left--;
         pattern_pos++;
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= stall_pattern[pattern_pos % 8];
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   // sender bursts: random length, random gap after each unless gaps are off
   task automatic pace_sender();
      if (burst_left == 0) begin
         if (gaps_on) begin
            repeat ($urandom_range(1, 6)) begin
               @(negedge clock);
               req_valid <= 1'b0;
            end
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // one word on req; valid stays up until the next call or a gap drops it
   task automatic send_tick(bit tick);
      pace_sender();
      @(negedge clock);
      req_valid      <= 1'b1;
      req_frame_tick <= tick;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      advance_frame(tick);
   endtask

   task automatic send_ticks(int unsigned count);
      repeat (count) begin
         send_tick(1'b1);
      end
   endtask

   // sender holds off until every predicted word is out, then lets a
   // silent tick finish before anything else happens
   task automatic drain_pixels();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // only called with the block idle
   task automatic write_reg(logic [1:0] idx, logic [ledanim_pkg::COLOR_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         ledanim_pkg::REG_POWER:  cfg_power  = value[0];
         ledanim_pkg::REG_MODE:   cfg_mode   = value[2:0];
         ledanim_pkg::REG_COLOR:  cfg_color  = value;
         ledanim_pkg::REG_LENGTH: cfg_length = value[ledanim_pkg::LEN_W-1:0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // power off after reset: full 32-pixel black frames at level 255;
   // a word without frame_tick does nothing
   task automatic test_power_off();
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      drain_pixels();
   endtask

   // mode 7 right after reset matches the "none yet" state: silent;
   // mode 6 clears once and is silent afterwards
   task automatic test_unknown_modes();
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_NONE});
      write_reg(ledanim_pkg::REG_POWER, 24'd1);
      send_tick(1'b1);
      drain_pixels();
      write_reg(ledanim_pkg::REG_MODE, {21'd0, MODE_UNUSED});
      send_ticks(2);
      drain_pixels();
   endtask

   // solid at both color extremes and the length corners, including the
   // out-of-range lengths that clamp
   task automatic test_solid_extremes();
      write_reg(ledanim_pkg::REG_COLOR, 24'hFFFFFF);
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_SOLID});
      send_ticks(2);
      drain_pixels();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd0);
      send_tick(1'b1);
      drain_pixels();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd63);
      write_reg(ledanim_pkg::REG_COLOR, 24'h000000);
      send_tick(1'b1);
      drain_pixels();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd33);
      write_reg(ledanim_pkg::REG_COLOR, 24'hA5C35A);
      send_tick(1'b1);
      drain_pixels();
      // powered off keeps the mode: no clear frame on the way back
      write_reg(ledanim_pkg::REG_POWER, 24'd0);
      send_tick(1'b1);
      drain_pixels();
      write_reg(ledanim_pkg::REG_POWER, 24'd1);
      send_tick(1'b1);
      drain_pixels();
   endtask

   // wipe part way through a pass, then shrink the length under the running index
   task automatic test_wipe_shrink();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd8);
      write_reg(ledanim_pkg::REG_COLOR, 24'h123456);
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_WIPE});
      send_ticks(7);
      drain_pixels();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd3);
      send_ticks(6);
      drain_pixels();
   endtask

   // theater chase through its three offsets and the silent wrap step
   task automatic test_chase();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd10);
      write_reg(ledanim_pkg::REG_COLOR, 24'($urandom));
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_CHASE});
      send_ticks(9);
      drain_pixels();
   endtask

   // breathe rising on a one-pixel strip: level follows the step
   task automatic test_breathe_cycle();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd1);
      write_reg(ledanim_pkg::REG_COLOR, 24'($urandom));
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_BREATHE});
      send_ticks(24);
      drain_pixels();
   endtask

   // rainbow steps along the wheel on a short strip
   task automatic test_rainbow();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd3);
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_RAINBOW});
      send_ticks(12);
      drain_pixels();
   endtask

   // rainbow chase: seven words per step, a little over two steps
   task automatic test_rainbow_chase();
      write_reg(ledanim_pkg::REG_LENGTH, 24'd4);
      write_reg(ledanim_pkg::REG_MODE, {21'd0, ledanim_pkg::MODE_RCHASE});
      send_ticks(16);
      drain_pixels();
   endtask

   // random settings per phase, short lengths mostly; upper csr_data bits
   // are random to show that only the register width is used
   task automatic test_random_settings();
      int unsigned done_ticks;
      int unsigned sel;
      int unsigned len_val;
      logic [2:0]  mode_val;
      logic [ledanim_pkg::COLOR_W-1:0] color_val;
      done_ticks = 0;
      while (done_ticks < RANDOM_TICKS) begin
         drain_pixels();
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 2) == 0) begin
            write_reg(ledanim_pkg::REG_POWER,
                      {23'($urandom), ($urandom_range(0, 5) != 0)});
         end
         if ($urandom_range(0, 2) != 0) begin
            mode_val = ($urandom_range(0, 11) == 0) ?
                       3'($urandom_range(MODE_UNUSED, ledanim_pkg::MODE_NONE)) :
                       3'($urandom_range(ledanim_pkg::MODE_SOLID,
                                         ledanim_pkg::MODE_RCHASE));
            write_reg(ledanim_pkg::REG_MODE, {21'($urandom), mode_val});
         end
         if ($urandom_range(0, 1) == 0) begin
            sel = $urandom_range(0, 9);
            color_val = (sel == 0) ? 24'h000000 :
                        (sel == 1) ? 24'hFFFFFF : 24'($urandom);
            write_reg(ledanim_pkg::REG_COLOR, color_val);
         end
         if ($urandom_range(0, 1) == 0) begin
            sel = $urandom_range(0, 19);
            if (sel < 14) begin
               len_val = $urandom_range(1, 8);
            end else if (sel < 17) begin
               len_val = $urandom_range(9, ledanim_pkg::MAX_PIXELS);
            end else if (sel == 17) begin
               len_val = 0;
            end else begin
               len_val = $urandom_range(ledanim_pkg::MAX_PIXELS + 1, 63);
            end
            write_reg(ledanim_pkg::REG_LENGTH, {18'($urandom), 6'(len_val)});
         end
         repeat ($urandom_range(3, 20)) begin
            // ticks without frame_tick are ignored and not counted
            if ($urandom_range(0, 9) == 0) begin
               send_tick(1'b0);
            end else begin
               send_tick(1'b1);
               done_ticks++;
            end
         end
      end
      gaps_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      // predicted state and settings out of reset
      foreach (strip_img[i]) begin
         strip_img[i] = '0;
      end
      step_cnt     = 0;
      chase_ofs    = 0;
      breathe_down = 1'b0;
      wipe_black   = 1'b0;
      chase_on     = 1'b0;
      shown_mode   = ledanim_pkg::MODE_NONE;
      level        = 8'hFF;
      cfg_power    = 1'b0;
      cfg_mode     = ledanim_pkg::MODE_SOLID;
      cfg_color    = '0;
      cfg_length   = ledanim_pkg::LEN_W'(ledanim_pkg::MAX_PIXELS);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_off();
      test_unknown_modes();
      test_solid_extremes();
      test_wipe_shrink();
      test_chase();
      test_breathe_cycle();
      test_rainbow();
      test_rainbow_chase();
      test_random_settings();
      drain_pixels();

      if (mismatch_count == 0 && pending_pixels.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
